// ===== hdl/dpd_pkg.sv =====
// shared types, character codes and result kinds of the debug packet deframer
// no dependencies; used by every module in hdl
package dpd_pkg;

  localparam int unsigned MaxPacketDef = 1024;
  localparam int unsigned LenW         = 10;
  localparam int unsigned MaxRes       = 3;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChIntr   = 8'h03;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;

  localparam logic [2:0] KindData    = 3'd0;
  localparam logic [2:0] KindAccept  = 3'd1;
  localparam logic [2:0] KindBadSum  = 3'd2;
  localparam logic [2:0] KindAbandon = 3'd3;
  localparam logic [2:0] KindIntr    = 3'd4;

  typedef struct packed {
    logic [2:0]      kind;
    logic [7:0]      data_byte;
    logic [7:0]      reply_char;
    logic            has_sequence;
    logic [7:0]      sequence_first;
    logic [7:0]      sequence_second;
    logic [LenW-1:0] payload_length;
  } result_t;

  // results of one received byte, slot 0 first
  typedef struct packed {
    logic [1:0]        n;
    result_t [MaxRes-1:0] res;
  } bundle_t;

  function automatic result_t mk_res(logic [2:0] kind, logic [7:0] data, logic [7:0] reply,
                                     logic hs, logic [7:0] s1, logic [7:0] s2,
                                     logic [LenW-1:0] len);
    result_t r;
    r.kind            = kind;
    r.data_byte       = data;
    r.reply_char      = reply;
    r.has_sequence    = hs;
    r.sequence_first  = s1;
    r.sequence_second = s2;
    r.payload_length  = len;
    return r;
  endfunction

  // non-hex characters count as zero
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== hdl/dpd_core.sv =====
// packet state machine of the debug packet deframer: checksum, byte count,
// held bytes and the results of one byte; depends on dpd_pkg
module dpd_core #(
  parameter int unsigned MAX_PACKET = dpd_pkg::MaxPacketDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             fire_i,
  output dpd_pkg::bundle_t bundle_o
);

  localparam int unsigned CntW = $clog2(MAX_PACKET);

  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhBody = 2'd1;
  localparam logic [1:0] PhHi   = 2'd2;
  localparam logic [1:0] PhLo   = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]      hi_q, hi_d;
  logic            seq_q, seq_d;
  logic [1:0][7:0] held_q;
  logic            held_we;

  logic [CntW-1:0] streamed;
  logic [CntW-1:0] streamed_nx;
  logic [7:0]      expect_sum;
  logic [dpd_pkg::LenW-1:0] len_now;

  assign streamed    = seq_q ? cnt_q - CntW'(3) : cnt_q;
  assign streamed_nx = streamed + CntW'(1);
  assign expect_sum  = {hi_q, dpd_pkg::hex_val(byte_i)};
  assign len_now     = dpd_pkg::LenW'(streamed);

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    hi_d        = hi_q;
    seq_d       = seq_q;
    held_we     = 1'b0;
    bundle_o    = '0;

    unique case (phase_q)
      PhHunt: begin
        if (byte_i == dpd_pkg::ChDollar) begin
          phase_d = PhBody;
          sum_d   = '0;
          cnt_d   = '0;
          seq_d   = 1'b0;
          hi_d    = '0;
        end else if (byte_i == dpd_pkg::ChIntr) begin
          bundle_o.n      = 2'd1;
          bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindIntr, 8'd0, 8'd0, 1'b0,
                                            8'd0, 8'd0, '0);
        end
      end
      PhBody: begin
        if (byte_i == dpd_pkg::ChDollar) begin
          // restart: abandon the open packet and open a new one
          bundle_o.n      = 2'd1;
          bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindAbandon, 8'd0, 8'd0, 1'b0,
                                            8'd0, 8'd0,
                                            (cnt_q > CntW'(2)) ? len_now : '0);
          sum_d = '0;
          cnt_d = '0;
          seq_d = 1'b0;
          hi_d  = '0;
        end else if (byte_i == dpd_pkg::ChHash) begin
          // short payload: release the held bytes now
          if (cnt_q < CntW'(3)) begin
            bundle_o.n      = 2'(cnt_q);
            bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindData, held_q[0], 8'd0, 1'b0,
                                              8'd0, 8'd0, dpd_pkg::LenW'(1));
            bundle_o.res[1] = dpd_pkg::mk_res(dpd_pkg::KindData, held_q[1], 8'd0, 1'b0,
                                              8'd0, 8'd0, dpd_pkg::LenW'(2));
          end
          phase_d = PhHi;
        end else begin
          sum_d = sum_q + byte_i;
          if (cnt_q < CntW'(2)) begin
            held_we = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
          end else if (cnt_q == CntW'(2)) begin
            cnt_d = CntW'(3);
            if (byte_i == dpd_pkg::ChColon) begin
              seq_d = 1'b1;
            end else begin
              bundle_o.n      = 2'd3;
              bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindData, held_q[0], 8'd0, 1'b0,
                                                8'd0, 8'd0, dpd_pkg::LenW'(1));
              bundle_o.res[1] = dpd_pkg::mk_res(dpd_pkg::KindData, held_q[1], 8'd0, 1'b0,
                                                8'd0, 8'd0, dpd_pkg::LenW'(2));
              bundle_o.res[2] = dpd_pkg::mk_res(dpd_pkg::KindData, byte_i, 8'd0, 1'b0,
                                                8'd0, 8'd0, dpd_pkg::LenW'(3));
            end
          end else begin
            cnt_d           = cnt_q + CntW'(1);
            bundle_o.n      = 2'd1;
            bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindData, byte_i, 8'd0, 1'b0,
                                              8'd0, 8'd0, dpd_pkg::LenW'(streamed_nx));
            // payload limit reached: only possible past the held bytes
            if (cnt_d >= CntW'(MAX_PACKET - 1)) begin
              bundle_o.n      = 2'd2;
              bundle_o.res[1] = dpd_pkg::mk_res(dpd_pkg::KindAbandon, 8'd0, 8'd0, 1'b0,
                                                8'd0, 8'd0, dpd_pkg::LenW'(streamed_nx));
              phase_d = PhHunt;
            end
          end
        end
      end
      PhHi: begin
        hi_d    = dpd_pkg::hex_val(byte_i);
        phase_d = PhLo;
      end
      PhLo: begin
        bundle_o.n = 2'd1;
        if (expect_sum == sum_q) begin
          bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindAccept, 8'd0, dpd_pkg::ChPlus,
                                            seq_q, seq_q ? held_q[0] : 8'd0,
                                            seq_q ? held_q[1] : 8'd0, len_now);
        end else begin
          bundle_o.res[0] = dpd_pkg::mk_res(dpd_pkg::KindBadSum, 8'd0, dpd_pkg::ChMinus,
                                            1'b0, 8'd0, 8'd0, len_now);
        end
        phase_d = PhHunt;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      sum_q   <= '0;
      cnt_q   <= '0;
      hi_q    <= '0;
      seq_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
      seq_q   <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && held_we) begin
      held_q[cnt_q[0]] <= byte_i;
    end
  end

  // a stripped sequence id always means three bytes were counted
  a_seq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q |-> (cnt_q >= CntW'(3)))
    else $error("sequence flag set with fewer than three bytes");

  // an open packet never sits at the payload limit
  a_body_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBody) |-> (cnt_q < CntW'(MAX_PACKET - 1)))
    else $error("open packet at payload limit");

endmodule

// ===== hdl/dpd_outq.sv =====
// result register of the debug packet deframer: holds the results of one byte
// and hands them out one word per cycle while the output is ready; depends on dpd_pkg
module dpd_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  dpd_pkg::bundle_t             bundle_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dpd_pkg::result_t             res_o,
  output logic                         last_o
);

  logic [1:0]                           n_q;
  logic [1:0]                           idx_q;
  dpd_pkg::result_t [dpd_pkg::MaxRes-1:0] res_q;
  logic                                 take;

  assign out_valid_o = (n_q != 2'd0);
  assign last_o      = (idx_q == n_q - 2'd1);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (take && last_o);
  assign res_o       = res_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      n_q   <= bundle_i.n;
      idx_q <= '0;
    end else if (take) begin
      if (last_o) begin
        n_q   <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < n_q))
    else $error("result index past result count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("results loaded over pending words");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_o && !load_i) |=> !out_valid_o)
    else $error("output still valid after last word taken");

endmodule

// ===== hdl/debug_packet_deframer_top.sv =====
// top level of the debug packet deframer: input byte register, packet state
// machine and result register; depends on dpd_pkg, dpd_core, dpd_outq
//
// Receives one byte per word and recognizes debugger packets "$payload#hh".
// Outside a packet, byte 0x03 gives an interrupt word and other bytes are
// dropped. Payload bytes stream out as data words (the first two are held
// until the third shows whether they form a sequence id "xx:", which is
// stripped); the two checksum digits end the packet with an accept word ('+',
// sequence id echoed) or a bad-checksum word ('-'). A '$' inside a packet or
// reaching MAX_PACKET-1 payload bytes gives an abandon word. A byte is taken
// every cycle unless its results wait for the result register. A byte that
// causes k result words (k is at most three) holds the result register until
// all k are taken, so the output port sets the sustained rate; the input
// register takes one more byte while results wait.
module debug_packet_deframer_top #(
  parameter int unsigned MAX_PACKET = dpd_pkg::MaxPacketDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               kind_o,
  output logic [7:0]               data_byte_o,
  output logic [7:0]               reply_char_o,
  output logic                     has_sequence_o,
  output logic [7:0]               sequence_first_o,
  output logic [7:0]               sequence_second_o,
  output logic [dpd_pkg::LenW-1:0] payload_length_o,
  output logic                     last_o
);

  logic             in_vq;
  logic [7:0]       in_q;
  logic             fire;
  logic             free;
  dpd_pkg::bundle_t bundle;
  dpd_pkg::result_t res;

  // a byte with no results never waits for the result register
  assign fire       = in_vq && ((bundle.n == 2'd0) || free);
  assign in_ready_o = !in_vq || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vq <= 1'b1;
    end else if (fire) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= rx_byte_i;
    end
  end

  dpd_core #(
    .MAX_PACKET(MAX_PACKET)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (in_q),
    .fire_i  (fire),
    .bundle_o(bundle)
  );

  dpd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && (bundle.n != 2'd0)),
    .bundle_i   (bundle),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res),
    .last_o     (last_o)
  );

  assign kind_o            = res.kind;
  assign data_byte_o       = res.data_byte;
  assign reply_char_o      = res.reply_char;
  assign has_sequence_o    = res.has_sequence;
  assign sequence_first_o  = res.sequence_first;
  assign sequence_second_o = res.sequence_second;
  assign payload_length_o  = res.payload_length;

endmodule

// ===== sim/debug_packet_deframer_top_test.sv =====
// testbench for debug_packet_deframer_top: drives received bytes, predicts the
// result words in a scoreboard class and checks them; depends on dpd_pkg and
// the deframer rtl only
`timescale 1ns / 100ps

module debug_packet_deframer_top_test;
  import dpd_pkg::*;

  localparam int MaxPacket  = MaxPacketDef;
  localparam int StallLimit = 2000;
  localparam int RandItems  = 280;
  localparam int MaxReports = 100;

  typedef enum logic [1:0] {
    Hunt,
    Body,
    SumHi,
    SumLo
  } rx_phase_e;

  typedef struct packed {
    result_t fields;
    logic    last;
  } out_word_t;

  class deframe_checker;
    rx_phase_e  phase;
    logic [7:0] sum_acc;
    int         count;
    logic [7:0] held [2];
    logic [3:0] hi_nib;
    bit         seq_seen;
    out_word_t  expected_words[$];
    out_word_t  staged[$];
    int         errors;
    int         reports;

    function new();
      phase    = Hunt;
      sum_acc  = 8'h00;
      count    = 0;
      held[0]  = 8'h00;
      held[1]  = 8'h00;
      hi_nib   = 4'h0;
      seq_seen = 1'b0;
      errors   = 0;
      reports  = 0;
    endfunction

    function int stripped_len();
      return seq_seen ? count - 3 : count;
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
      if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
      return 4'h0;
    endfunction

    function void stage(logic [2:0] kind, logic [7:0] data, logic [7:0] reply, logic hs,
                        logic [7:0] s1, logic [7:0] s2, int len);
      out_word_t w;
      w.fields.kind            = kind;
      w.fields.data_byte       = data;
      w.fields.reply_char      = reply;
      w.fields.has_sequence    = hs;
      w.fields.sequence_first  = s1;
      w.fields.sequence_second = s2;
      w.fields.payload_length  = LenW'(len);
      w.last                   = 1'b0;
      staged.push_back(w);
    endfunction

    function void start_packet();
      phase    = Body;
      sum_acc  = 8'h00;
      count    = 0;
      seq_seen = 1'b0;
      hi_nib   = 4'h0;
    endfunction

    // works out the words one received byte causes and queues them
    function void predict_words(logic [7:0] c);
      logic [7:0] want;
      int         len;
      out_word_t  w;
      staged.delete();
      case (phase)
        Hunt: begin
          if (c == ChDollar) begin
            start_packet();
          end else if (c == ChIntr) begin
            stage(KindIntr, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 0);
          end
        end
        Body: begin
          if (c == ChDollar) begin
            stage(KindAbandon, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00,
                  count > 2 ? stripped_len() : 0);
            start_packet();
          end else if (c == ChHash) begin
            // short payload: held bytes go out only now
            if (count < 3) begin
              for (int i = 0; i < count; i++) begin
                stage(KindData, held[i], 8'h00, 1'b0, 8'h00, 8'h00, i + 1);
              end
            end
            phase = SumHi;
          end else begin
            sum_acc = sum_acc + c;
            if (count < 2) begin
              held[count] = c;
              count++;
            end else if (count == 2) begin
              count = 3;
              if (c == ChColon) begin
                seq_seen = 1'b1;
              end else begin
                stage(KindData, held[0], 8'h00, 1'b0, 8'h00, 8'h00, 1);
                stage(KindData, held[1], 8'h00, 1'b0, 8'h00, 8'h00, 2);
                stage(KindData, c, 8'h00, 1'b0, 8'h00, 8'h00, 3);
              end
            end else begin
              count++;
              stage(KindData, c, 8'h00, 1'b0, 8'h00, 8'h00, stripped_len());
            end
            if (count >= MaxPacket - 1) begin
              stage(KindAbandon, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00,
                    count < 3 ? 0 : stripped_len());
              phase = Hunt;
            end
          end
        end
        SumHi: begin
          hi_nib = digit_value(c);
          phase  = SumLo;
        end
        default: begin
          want = {hi_nib, digit_value(c)};
          len  = count < 3 ? count : stripped_len();
          if (want == sum_acc) begin
            stage(KindAccept, 8'h00, ChPlus, seq_seen, seq_seen ? held[0] : 8'h00,
                  seq_seen ? held[1] : 8'h00, len);
          end else begin
            stage(KindBadSum, 8'h00, ChMinus, 1'b0, 8'h00, 8'h00, len);
          end
          phase = Hunt;
        end
      endcase
      foreach (staged[i]) begin
        w      = staged[i];
        w.last = (i == staged.size() - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        errors++;
        if (reports < MaxReports) begin
          reports++;
          $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
        end
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        errors++;
        if (reports < MaxReports) begin
          reports++;
          $display("%0t: word kind expected none, got 0x%0h", $time, got.fields.kind);
        end
        return;
      end
      want = expected_words.pop_front();
      compare_field("kind", want.fields.kind, got.fields.kind);
      compare_field("data_byte", want.fields.data_byte, got.fields.data_byte);
      compare_field("reply_char", want.fields.reply_char, got.fields.reply_char);
      compare_field("has_sequence", want.fields.has_sequence, got.fields.has_sequence);
      compare_field("sequence_first", want.fields.sequence_first,
                    got.fields.sequence_first);
      compare_field("sequence_second", want.fields.sequence_second,
                    got.fields.sequence_second);
      compare_field("payload_length", want.fields.payload_length,
                    got.fields.payload_length);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i   = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          kind_o;
  logic [7:0]          data_byte_o;
  logic [7:0]          reply_char_o;
  logic                has_sequence_o;
  logic [7:0]          sequence_first_o;
  logic [7:0]          sequence_second_o;
  logic [LenW-1:0]     payload_length_o;
  logic                last_o;

  deframe_checker chk;
  int             idle_pct = 34;
  int             bytes_sent = 0;

  debug_packet_deframer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .data_byte_o       (data_byte_o),
    .reply_char_o      (reply_char_o),
    .has_sequence_o    (has_sequence_o),
    .sequence_first_o  (sequence_first_o),
    .sequence_second_o (sequence_second_o),
    .payload_length_o  (payload_length_o),
    .last_o            (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  // input words go to the predictor before output words are checked
  always @(posedge clk_i) begin : monitor
    out_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        chk.predict_words(rx_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        w.fields.kind            = kind_o;
        w.fields.data_byte       = data_byte_o;
        w.fields.reply_char      = reply_char_o;
        w.fields.has_sequence    = has_sequence_o;
        w.fields.sequence_first  = sequence_first_o;
        w.fields.sequence_second = sequence_second_o;
        w.fields.payload_length  = payload_length_o;
        w.last                   = last_o;
        chk.check_word(w);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, StallLimit);
    $display("FAILURE");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == ChDollar || b == ChHash);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // checksum digit that may be a special or non-hex character
  function automatic logic [7:0] odd_digit();
    case ($urandom_range(4))
      0:       return ChDollar;
      1:       return ChHash;
      2:       return ChIntr;
      3:       return hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_packet(input int len, input bit with_seq, input bit sum_ok,
                             input bit close);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    send_byte(ChDollar);
    if (with_seq) begin
      repeat (2) begin
        b   = body_byte();
        sum = sum + b;
        send_byte(b);
      end
      sum = sum + ChColon;
      send_byte(ChColon);
    end
    for (int i = 0; i < len; i++) begin
      b   = body_byte();
      sum = sum + b;
      send_byte(b);
    end
    if (close) begin
      send_byte(ChHash);
      if (sum_ok) begin
        send_byte(hex_char(sum[7:4], 1'($urandom_range(1))));
        send_byte(hex_char(sum[3:0], 1'($urandom_range(1))));
      end else begin
        send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        send_byte(odd_digit());
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] opening[$];
    int         random_items;
    int         mark;
    int         len;
    bit         long_done[3];
    chk = new();
    opening = '{
      ChIntr, 8'h00, 8'hFF,                            // interrupt, dropped bytes
      ChDollar, ChHash, 8'h30, 8'h30,                  // empty payload
      ChDollar, 8'hFF, ChDollar, 8'h00, ChHash, 8'h66, 8'h46, // restart, bad sum
      ChDollar, 8'h31, 8'h32, ChColon, ChHash, 8'h39, 8'h44,  // sequence id only
      ChDollar, ChHash, ChDollar, ChHash               // specials as checksum digits
    };
    random_items = 0;
    long_done    = '{1'b0, 1'b0, 1'b0};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);

    while (random_items < RandItems) begin
      // one stretch with no idling on either side
      idle_pct = (random_items >= 100 && random_items < 170) ? 0 : 34;
      if (random_items >= 60 && !long_done[0]) begin
        send_packet(MaxPacket - 1, 1'b0, 1'b1, 1'b0);
        long_done[0] = 1'b1;
      end
      if (random_items >= 140 && !long_done[1]) begin
        send_packet(MaxPacket - 4, 1'b1, 1'b1, 1'b0);
        long_done[1] = 1'b1;
      end
      if (random_items >= 220 && !long_done[2]) begin
        send_packet(MaxPacket - 2, 1'b0, 1'b1, 1'b1);
        long_done[2] = 1'b1;
      end
      mark = bytes_sent;
      len  = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(4);
      case ($urandom_range(99)) inside
        [0:54]: begin
          send_packet(len, $urandom_range(2) == 0, $urandom_range(3) != 0, 1'b1);
        end
        [55:64]: begin
          send_byte(ChIntr);
        end
        [65:74]: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
        end
        [75:84]: begin
          send_byte(ChDollar);
          repeat ($urandom_range(4)) send_byte(body_byte());
          send_packet(len, $urandom_range(1), 1'b1, 1'b1);
        end
        [85:94]: begin
          send_packet(len, $urandom_range(3) == 0, 1'b1, 1'b0);
          send_byte(ChHash);
          send_byte(odd_digit());
          send_byte(odd_digit());
        end
        default: begin
          // cut off, whatever follows lands inside the packet
          send_packet($urandom_range(5), 1'b0, 1'b1, 1'b0);
        end
      endcase
      random_items += bytes_sent - mark;
    end
    idle_pct = 34;
    in_valid_i <= 1'b0;

    while (chk.expected_words.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (chk.expected_words.size() != 0) begin
      $display("%0t: %0d expected words never came", $time, chk.expected_words.size());
    end
    if (chk.errors == 0 && chk.expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== debug_packet_deframer_top.f =====
hdl/dpd_pkg.sv
hdl/dpd_core.sv
hdl/dpd_outq.sv
hdl/debug_packet_deframer_top.sv
sim/debug_packet_deframer_top_test.sv
